[sv/qec_pkg.sv]
// qec_pkg: shared types, constants and the transition table for the
// quadrature encoder counter. No dependencies.
package qec_pkg;

  localparam int unsigned WordW  = 15;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WordW-1:0] PhaseKeep = 15'h001C;
  localparam logic [WordW-1:0] IncBits   = 15'h0700;
  localparam logic [WordW-1:0] DecBits   = 15'h7000;
  localparam logic [WordW-1:0] CwBit     = 15'h0010;
  localparam logic [WordW-1:0] MaskReset = 15'h77FF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RES_MASK  = 2'd0,
    REG_COUNT_MIN = 2'd1,
    REG_COUNT_MAX = 2'd2,
    REG_INDEX_EN  = 2'd3
  } cfg_reg_t;

  // decoded phase step handed from the table stage to the counter
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             inc;
    logic             dec;
  } qec_decode_t;

  function automatic logic [WordW-1:0] trans_table(input logic [4:0] sel);
    logic [WordW-1:0] e;
    case (sel)
      5'd0:  e = 15'h0000;  5'd1:  e = 15'h0435;  5'd2:  e = 15'h0002;
      5'd3:  e = 15'h100F;  5'd4:  e = 15'h0004;  5'd5:  e = 15'h0005;
      5'd6:  e = 15'h4002;  5'd7:  e = 15'h013B;  5'd8:  e = 15'h2004;
      5'd9:  e = 15'h0009;  5'd10: e = 15'h043E;  5'd11: e = 15'h000B;
      5'd12: e = 15'h0230;  5'd13: e = 15'h4009;  5'd14: e = 15'h000E;
      5'd15: e = 15'h000F;  5'd16: e = 15'h0010;  5'd17: e = 15'h0415;
      5'd18: e = 15'h0012;  5'd19: e = 15'h102F;  5'd20: e = 15'h0014;
      5'd21: e = 15'h0015;  5'd22: e = 15'h4022;  5'd23: e = 15'h011B;
      5'd24: e = 15'h2024;  5'd25: e = 15'h0019;  5'd26: e = 15'h041E;
      5'd27: e = 15'h001B;  5'd28: e = 15'h0210;  5'd29: e = 15'h4029;
      5'd30: e = 15'h001E;  5'd31: e = 15'h001F;
      default: e = 15'h0000;
    endcase
    return e;
  endfunction

endpackage

[sv/qec_phase_decode.sv]
// qec_phase_decode: transition table lookup and resolution masking.
// Depends on qec_pkg.
module qec_phase_decode (
  input  logic [qec_pkg::WordW-1:0] phase_word,
  input  logic                      phase_a,
  input  logic                      phase_b,
  input  logic [qec_pkg::WordW-1:0] res_mask,
  output qec_pkg::qec_decode_t      dec_o
);

  logic [4:0]                sel;
  logic [qec_pkg::WordW-1:0] word;

  assign sel  = phase_word[4:0] & qec_pkg::PhaseKeep[4:0] | {3'b000, phase_b, phase_a};
  assign word = qec_pkg::trans_table(sel) & res_mask;

  assign dec_o.word = word;
  assign dec_o.inc  = |(word & qec_pkg::IncBits);
  assign dec_o.dec  = |(word & qec_pkg::DecBits);

endmodule

[sv/qec_count_step.sv]
// qec_count_step: saturating up/down step of the position counter with
// index clear. Depends on qec_pkg.
module qec_count_step (
  input  logic signed [qec_pkg::CountW-1:0] position,
  input  qec_pkg::qec_decode_t              dec_i,
  input  logic signed [qec_pkg::CountW-1:0] count_min,
  input  logic signed [qec_pkg::CountW-1:0] count_max,
  input  logic                              index_en,
  input  logic                              index_level,
  output logic signed [qec_pkg::CountW-1:0] position_nxt,
  output logic                              stepped
);

  localparam int unsigned WideW = qec_pkg::CountW + 1;

  logic signed [WideW-1:0] up, hi, pos_inc, dn, lo, pos_dec;

  always_comb begin
    // wide arithmetic so the top and bottom of range never wrap
    up      = {position[qec_pkg::CountW-1], position} + WideW'(1);
    hi      = {count_max[qec_pkg::CountW-1], count_max};
    pos_inc = dec_i.inc ? ((up < hi) ? up : hi) : {position[qec_pkg::CountW-1], position};
    dn      = pos_inc - WideW'(1);
    lo      = {count_min[qec_pkg::CountW-1], count_min};
    pos_dec = dec_i.dec ? ((dn > lo) ? dn : lo) : pos_inc;
    stepped = dec_i.inc | dec_i.dec;
    if (stepped && index_en && index_level) begin
      position_nxt = '0;
    end else begin
      position_nxt = pos_dec[qec_pkg::CountW-1:0];
    end
  end

endmodule

[sv/quadrature_encoder_counter_unit.sv]
// quadrature_encoder_counter_unit: x4 quadrature decoder with 1x/2x/4x
// resolution and a saturating position counter.
// The result of an input transfer is captured in the output register; the
// table lookup and saturating step sit between the phase/position state
// and that register. Throughput: one item per cycle unless the output stalls.
// Reset (synchronous, rst_n low): state cleared, config registers to reset values, result registers not reset.
module quadrature_encoder_counter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [qec_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [qec_pkg::CfgW-1:0]          cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_phase_a,
  input  logic                              in_phase_b,
  input  logic                              in_index_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [qec_pkg::CountW-1:0] out_count,
  output logic                              out_count_changed,
  output logic                              out_direction_cw
);

  logic [qec_pkg::WordW-1:0]         res_mask_r;
  logic signed [qec_pkg::CountW-1:0] count_min_r, count_max_r;
  logic                              index_en_r;
  logic [qec_pkg::WordW-1:0]         phase_word_r;
  logic signed [qec_pkg::CountW-1:0] position_r, position_nxt;
  logic                              out_valid_r;
  logic signed [qec_pkg::CountW-1:0] out_count_r;
  logic                              out_changed_r, out_cw_r;
  logic                              stepped, in_xfer;
  qec_pkg::qec_decode_t              dec;

  // a new transfer is taken whenever the output slot is free or draining
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  qec_phase_decode u_decode (
    .phase_word (phase_word_r),
    .phase_a    (in_phase_a),
    .phase_b    (in_phase_b),
    .res_mask   (res_mask_r),
    .dec_o      (dec)
  );

  qec_count_step u_step (
    .position     (position_r),
    .dec_i        (dec),
    .count_min    (count_min_r),
    .count_max    (count_max_r),
    .index_en     (index_en_r),
    .index_level  (in_index_level),
    .position_nxt (position_nxt),
    .stepped      (stepped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_mask_r  <= qec_pkg::MaskReset;
      count_min_r <= {1'b1, {(qec_pkg::CountW-1){1'b0}}};
      count_max_r <= {1'b0, {(qec_pkg::CountW-1){1'b1}}};
      index_en_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (qec_pkg::cfg_reg_t'(cfg_index))
        qec_pkg::REG_RES_MASK:  res_mask_r  <= cfg_wdata[qec_pkg::WordW-1:0];
        qec_pkg::REG_COUNT_MIN: count_min_r <= cfg_wdata;
        qec_pkg::REG_COUNT_MAX: count_max_r <= cfg_wdata;
        qec_pkg::REG_INDEX_EN:  index_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_word_r <= '0;
      position_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_word_r <= dec.word;
        position_r   <= position_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_count_r   <= position_nxt;
      out_changed_r <= stepped;
      out_cw_r      <= |(dec.word & qec_pkg::CwBit);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_count         = out_count_r;
  assign out_count_changed = out_changed_r;
  assign out_direction_cw  = out_cw_r;

  a_hold_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !dec.inc && !dec.dec) |=> (position_r == $past(position_r)))
    else $error("position moved without a step");

  a_index_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && stepped && index_en_r && in_index_level) |=> (position_r == '0))
    else $error("index did not clear counter");

  a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (out_valid_r && out_count_r == position_r))
    else $error("result register out of step with position");

endmodule

[dv/tb_quadrature_encoder_counter_unit.sv]
`timescale 1ns / 1ps
// tb_quadrature_encoder_counter_unit: self-checking bench for the quadrature counter,
// with a phase/position predictor, a result queue and randomised sender/receiver idling.
// Depends on qec_pkg and quadrature_encoder_counter_unit.
module tb_quadrature_encoder_counter_unit;
  import qec_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int WalkLength = 140;
  localparam int PhaseCount = 11;
  localparam logic signed [CountW-1:0] LowestCount = 32'h8000_0000;
  localparam logic signed [CountW-1:0] HighestCount = 32'h7FFF_FFFF;

  // next phase word, indexed by {old word[4:2], b, a}
  localparam logic [WordW-1:0] NextWord [32] = '{
    15'h0000, 15'h0435, 15'h0002, 15'h100F, 15'h0004, 15'h0005, 15'h4002, 15'h013B,
    15'h2004, 15'h0009, 15'h043E, 15'h000B, 15'h0230, 15'h4009, 15'h000E, 15'h000F,
    15'h0010, 15'h0415, 15'h0012, 15'h102F, 15'h0014, 15'h0015, 15'h4022, 15'h011B,
    15'h2024, 15'h0019, 15'h041E, 15'h001B, 15'h0210, 15'h4029, 15'h001E, 15'h001F
  };

  // opening samples as {index, b, a}: full turns both ways, jumps, holds, index
  localparam logic [2:0] OpeningDefault [13] = '{
    3'b000, 3'b001, 3'b011, 3'b010, 3'b000, 3'b010, 3'b011,
    3'b001, 3'b000, 3'b011, 3'b111, 3'b000, 3'b100
  };
  localparam logic [2:0] OpeningIndex [6] = '{
    3'b001, 3'b011, 3'b111, 3'b111, 3'b101, 3'b000
  };

  class count_predictor;
    typedef struct {
      logic signed [CountW-1:0] count;
      logic                     changed;
      logic                     cw;
    } step_t;

    logic [WordW-1:0]         mask;
    logic signed [CountW-1:0] lo;
    logic signed [CountW-1:0] hi;
    logic                     index_en;
    logic [WordW-1:0]         word;
    logic signed [CountW-1:0] pos;
    step_t                    due_steps[$];
    int                       errors;

    function new();
      mask = MaskReset;
      lo = LowestCount;
      hi = HighestCount;
      index_en = 1'b0;
      word = '0;
      pos = '0;
      errors = 0;
    endfunction

    function void note_config(cfg_reg_t r, logic [CfgW-1:0] d);
      case (r)
        REG_RES_MASK:  mask = d[WordW-1:0];
        REG_COUNT_MIN: lo = d;
        REG_COUNT_MAX: hi = d;
        REG_INDEX_EN:  index_en = d[0];
        default:       ;
      endcase
    endfunction

    function void note_transfer(logic a, logic b, logic ix);
      step_t s;
      longint nxt;
      logic inc;
      logic dec;
      word = NextWord[{word[4:2], b, a}] & mask;
      inc = |(word & IncBits);
      dec = |(word & DecBits);
      // limits are applied in full width, so the counter never wraps
      if (inc) begin
        nxt = longint'(pos) + 1;
        pos = (nxt < longint'(hi)) ? nxt[CountW-1:0] : hi;
      end
      if (dec) begin
        nxt = longint'(pos) - 1;
        pos = (nxt > longint'(lo)) ? nxt[CountW-1:0] : lo;
      end
      if ((inc || dec) && index_en && ix) pos = '0;
      s.count = pos;
      s.changed = inc || dec;
      s.cw = word[4];
      due_steps.insert(due_steps.size(), s);
    endfunction

    function void check_result(logic signed [CountW-1:0] count, logic changed, logic cw);
      step_t s;
      if (due_steps.size() == 0) begin
        $error("count: no transfer outstanding, got %0d", count);
        errors++;
        return;
      end
      s = due_steps.pop_front();
      if (count !== s.count) begin
        $error("count: expected %0d, got %0d", s.count, count);
        errors++;
      end
      if (changed !== s.changed) begin
        $error("count_changed: expected %0b, got %0b", s.changed, changed);
        errors++;
      end
      if (cw !== s.cw) begin
        $error("direction_cw: expected %0b, got %0b", s.cw, cw);
        errors++;
      end
    endfunction

    function int pending();
      return due_steps.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CfgIdxW-1:0]         cfg_index;
  logic [CfgW-1:0]            cfg_wdata;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_phase_a;
  logic                       in_phase_b;
  logic                       in_index_level;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [CountW-1:0]   out_count;
  logic                       out_count_changed;
  logic                       out_direction_cw;

  count_predictor sb = new();

  int burst_left = 0;
  int enc_ph = 0;
  int turn_dir = 1;
  int stall_mode = 0;
  int mode_left = 0;
  int run_left = 0;
  logic run_level = 1'b0;

  quadrature_encoder_counter_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_phase_a        (in_phase_a),
    .in_phase_b        (in_phase_b),
    .in_index_level    (in_index_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_count         (out_count),
    .out_count_changed (out_count_changed),
    .out_direction_cw  (out_direction_cw)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: stall behaviour switches between free-running, scattered and long runs
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_count, out_count_changed, out_direction_cw);
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (run_left == 0) begin
          run_level = ~run_level;
          run_left = $urandom_range(1, 8);
        end
        run_left--;
        out_stall <= run_level;
      end
    endcase
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_sample(logic a, logic b, logic ix);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_phase_a <= a;
    in_phase_b <= b;
    in_index_level <= ix;
    // payload is held until the transfer, so the prediction can be queued now
    sb.note_transfer(a, b, ix);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CfgW-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= d;
    @(posedge clk);
    sb.note_config(r, d);
  endtask

  // unused upper bits of the write data are randomised
  task automatic configure(logic [WordW-1:0] m, logic [CfgW-1:0] lo, logic [CfgW-1:0] hi,
                           logic ien);
    drain();
    write_reg(REG_RES_MASK, ($urandom & 32'hFFFF_8000) | {17'd0, m});
    write_reg(REG_COUNT_MIN, lo);
    write_reg(REG_COUNT_MAX, hi);
    write_reg(REG_INDEX_EN, ($urandom & 32'hFFFF_FFFE) | {31'd0, ien});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly clean gray-code turning with occasional reversals, plus noise samples
  task automatic walk(int n, int p_rev, int p_noise, int p_index);
    logic [1:0] g;
    logic ix;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < p_noise) begin
        enc_ph = $urandom_range(0, 3);
      end else begin
        if ($urandom_range(0, 99) < p_rev) turn_dir = -turn_dir;
        enc_ph = (enc_ph + turn_dir) & 3;
      end
      g = enc_ph[1:0] ^ (enc_ph[1:0] >> 1);
      ix = ($urandom_range(0, 99) < p_index);
      send_sample(g[0], g[1], ix);
    end
  endtask

  initial begin
    logic [CfgW-1:0] r_lo;
    logic [CfgW-1:0] r_hi;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_RES_MASK;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_phase_a <= 1'b0;
    in_phase_b <= 1'b0;
    in_index_level <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings first, index line ignored
    foreach (OpeningDefault[i])
      send_sample(OpeningDefault[i][0], OpeningDefault[i][1], OpeningDefault[i][2]);
    // index enabled: clear on a counted step, no clear while holding
    configure(MaskReset, LowestCount, HighestCount, 1'b1);
    foreach (OpeningIndex[i])
      send_sample(OpeningIndex[i][0], OpeningIndex[i][1], OpeningIndex[i][2]);

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: configure(15'h77FF, LowestCount, HighestCount, 1'b1);
        1: configure(15'h111F, -32'sd5, 32'sd7, 1'b0);
        2: configure(15'h331F, -32'sd3, 32'sd3, 1'b1);
        3: configure(15'h771F, 32'sd4, -32'sd4, 1'b0);
        // crossed at the extremes: pushes the counter to the ends of the range
        4: configure(15'h77FF, HighestCount, LowestCount, 1'b0);
        5: configure(15'h77FF, LowestCount, LowestCount, 1'b0);
        6: configure(15'h77FF, HighestCount, HighestCount, 1'b0);
        // counter left outside the new window
        7: configure(15'h771F, -32'sd5, 32'sd7, 1'b1);
        // phase bits masked off
        8: configure(15'h7700, -32'sd100, 32'sd100, 1'b1);
        9: configure(WordW'($urandom), $urandom, $urandom, 1'($urandom_range(0, 1)));
        default: begin
          r_lo = -$urandom_range(0, 50);
          r_hi = $urandom_range(0, 50);
          configure(WordW'($urandom), r_lo, r_hi, 1'($urandom_range(0, 1)));
        end
      endcase
      walk(WalkLength, $urandom_range(1, 10), (p >= 8) ? 25 : 8,
           (p % 3 == 0) ? 30 : 5);
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
